// ===== design/qte_pkg.sv =====
// Package for the quaternion to Euler angle converter.
// Holds datapath widths, angle constants, the CORDIC arctangent table and an angle saturation function.
// No dependencies.
`default_nettype none
package qte_pkg;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int ATAN_LEN = 24;

  localparam int QW  = 17;  // input component with room for negated z
  localparam int PW  = 34;  // product width
  localparam int TW  = 36;  // ZYX term width, 1.0 = 2^30
  localparam int XW  = 38;  // CORDIC vector width
  localparam int ZW  = 27;  // CORDIC angle, 2^-16 degree
  localparam int AW  = ZW - 9;  // angle after rounding to 1/128 degree
  localparam int SQN = 31;  // root bits
  localparam int SQW = 63;  // root datapath width

  localparam logic signed [ZW-1:0] DEG180_FINE = ZW'(180 * 65536);
  localparam logic signed [AW-1:0] FULL_SCALE  = AW'(23040);
  localparam logic signed [AW-1:0] HALF_SCALE  = AW'(11520);

  function automatic logic [22:0] atan_deg(input int idx);
    logic [22:0] v;
    case (idx)
      0:       v = 23'd2949120;
      1:       v = 23'd1740967;
      2:       v = 23'd919879;
      3:       v = 23'd466945;
      4:       v = 23'd234379;
      5:       v = 23'd117304;
      6:       v = 23'd58666;
      7:       v = 23'd29335;
      8:       v = 23'd14668;
      9:       v = 23'd7334;
      10:      v = 23'd3667;
      11:      v = 23'd1833;
      12:      v = 23'd917;
      13:      v = 23'd458;
      14:      v = 23'd229;
      15:      v = 23'd115;
      16:      v = 23'd57;
      17:      v = 23'd29;
      18:      v = 23'd14;
      19:      v = 23'd7;
      20:      v = 23'd4;
      21:      v = 23'd2;
      22:      v = 23'd1;
      default: v = 23'd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [AW-1:0] sat_ang(input logic signed [AW-1:0] a,
                                                   input logic signed [AW-1:0] lim);
    logic signed [AW-1:0] r;
    if (a > lim) begin
      r = lim;
    end else if (a < -lim) begin
      r = -lim;
    end else begin
      r = a;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== design/quaternion_to_euler_degrees.sv =====
// Path: input, product, term and square registers, root pipeline, CORDICs, output register.
// Throughput: one request per cycle; all stages advance together when the output
// register is empty or being taken.
// Reset: rst_n clears all valid bits; payload registers are not reset.
// Top level of the quaternion to ZYX Euler converter. Uses qte_pkg and qte_cordic.
`default_nettype none
module quaternion_to_euler_degrees #(
  parameter int CORDIC_STAGES = qte_pkg::CORDIC_STAGES_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [15:0] in_quat_w,
  input  wire logic signed [15:0] in_quat_x,
  input  wire logic signed [15:0] in_quat_y,
  input  wire logic signed [15:0] in_quat_z,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [15:0]      out_roll_angle,
  output logic signed [14:0]      out_pitch_angle,
  output logic signed [15:0]      out_yaw_angle,
  output logic                    out_pitch_clamped
);
  import qte_pkg::*;

  localparam int CL = CORDIC_STAGES + 2;

  logic adv;

  // stage 0: inputs
  logic                 v0_r;
  logic signed [QW-1:0] w0_r, x0_r, y0_r, z0_r;
  // stage 1: products
  logic                 v1_r;
  logic signed [PW-1:0] wx_r, yz_r, xx_r, yy_r, wy_r, zx_r, wz_r, xy_r, zz_r;
  // stage 2: terms
  logic                 v2_r;
  logic signed [TW-1:0] sr2_r, cr2_r, sp2_r, sy2_r, cy2_r;
  // stage 3: square of pitch term
  logic                 v3_r;
  logic signed [TW-1:0] sr3_r, cr3_r, sp3_r, sy3_r, cy3_r;
  logic                 clamp3_r;
  logic [59:0]          sq3_r;
  logic [29:0]          sp_abs;
  logic                 clamp2;

  // root pipeline, index 0 is stage 4
  logic                 sq_v_r     [0:SQN];
  logic [SQW-1:0]       sq_rad_r   [0:SQN];
  logic [SQW-1:0]       sq_res_r   [0:SQN];
  logic signed [TW-1:0] sq_sr_r    [0:SQN];
  logic signed [TW-1:0] sq_cr_r    [0:SQN];
  logic signed [TW-1:0] sq_sp_r    [0:SQN];
  logic signed [TW-1:0] sq_sy_r    [0:SQN];
  logic signed [TW-1:0] sq_cy_r    [0:SQN];
  logic                 sq_clamp_r [0:SQN];

  // side band across the CORDIC
  logic                 dl_v_r     [0:CL-1];
  logic                 dl_clamp_r [0:CL-1];
  logic                 dl_pos_r   [0:CL-1];

  logic signed [TW-1:0] cp_term;
  logic signed [AW-1:0] roll_ang, pitch_ang, yaw_ang;
  logic signed [AW-1:0] roll_sat, pitch_sat, yaw_sat;

  logic                 out_valid_r;
  logic signed [15:0]   roll_r, yaw_r;
  logic signed [14:0]   pitch_r;
  logic                 clamp_r;

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r        <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
      for (int k = 0; k <= SQN; k++) begin
        sq_v_r[k] <= 1'b0;
      end
      for (int k = 0; k < CL; k++) begin
        dl_v_r[k] <= 1'b0;
      end
    end else if (adv) begin
      v0_r        <= in_valid;
      v1_r        <= v0_r;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      sq_v_r[0]   <= v3_r;
      for (int k = 0; k < SQN; k++) begin
        sq_v_r[k+1] <= sq_v_r[k];
      end
      dl_v_r[0]   <= sq_v_r[SQN];
      for (int k = 0; k < CL - 1; k++) begin
        dl_v_r[k+1] <= dl_v_r[k];
      end
      out_valid_r <= dl_v_r[CL-1];
    end
  end

  assign clamp2 = (sp2_r >= TW'(64'sd1 <<< 30)) || (sp2_r <= -TW'(64'sd1 <<< 30));
  assign sp_abs = (sp2_r < 0) ? 30'(-sp2_r) : sp2_r[29:0];

  always_ff @(posedge clk) begin
    if (adv) begin
      w0_r  <= QW'(in_quat_w);
      x0_r  <= QW'(in_quat_x);
      y0_r  <= QW'(in_quat_y);
      z0_r  <= -QW'(in_quat_z);

      wx_r  <= w0_r * x0_r;
      yz_r  <= y0_r * z0_r;
      xx_r  <= x0_r * x0_r;
      yy_r  <= y0_r * y0_r;
      wy_r  <= w0_r * y0_r;
      zx_r  <= z0_r * x0_r;
      wz_r  <= w0_r * z0_r;
      xy_r  <= x0_r * y0_r;
      zz_r  <= z0_r * z0_r;

      sr2_r <= (TW'(wx_r) + TW'(yz_r)) <<< 1;
      cr2_r <= TW'(64'sd1 <<< 30) - ((TW'(xx_r) + TW'(yy_r)) <<< 1);
      sp2_r <= (TW'(wy_r) - TW'(zx_r)) <<< 1;
      sy2_r <= (TW'(wz_r) + TW'(xy_r)) <<< 1;
      cy2_r <= TW'(64'sd1 <<< 30) - ((TW'(yy_r) + TW'(zz_r)) <<< 1);

      sr3_r    <= sr2_r;
      cr3_r    <= cr2_r;
      sp3_r    <= sp2_r;
      sy3_r    <= sy2_r;
      cy3_r    <= cy2_r;
      clamp3_r <= clamp2;
      sq3_r    <= 60'(sp_abs) * 60'(sp_abs);

      sq_rad_r[0]   <= (SQW'(1) << 60) - SQW'(sq3_r);
      sq_res_r[0]   <= '0;
      sq_sr_r[0]    <= sr3_r;
      sq_cr_r[0]    <= cr3_r;
      sq_sp_r[0]    <= sp3_r;
      sq_sy_r[0]    <= sy3_r;
      sq_cy_r[0]    <= cy3_r;
      sq_clamp_r[0] <= clamp3_r;
    end
  end

  // digit-by-digit square root, one result bit per stage
  for (genvar k = 0; k < SQN; k++) begin : g_sqrt
    localparam int B = SQN - 1 - k;
    localparam logic [SQW-1:0] BITC = SQW'(1) << (2 * B);
    logic [SQW-1:0] trial;
    assign trial = sq_res_r[k] + BITC;
    always_ff @(posedge clk) begin
      if (adv) begin
        if (sq_rad_r[k] >= trial) begin
          sq_rad_r[k+1] <= sq_rad_r[k] - trial;
          sq_res_r[k+1] <= (sq_res_r[k] >> 1) + BITC;
        end else begin
          sq_rad_r[k+1] <= sq_rad_r[k];
          sq_res_r[k+1] <= sq_res_r[k] >> 1;
        end
        sq_sr_r[k+1]    <= sq_sr_r[k];
        sq_cr_r[k+1]    <= sq_cr_r[k];
        sq_sp_r[k+1]    <= sq_sp_r[k];
        sq_sy_r[k+1]    <= sq_sy_r[k];
        sq_cy_r[k+1]    <= sq_cy_r[k];
        sq_clamp_r[k+1] <= sq_clamp_r[k];
      end
    end
  end

  assign cp_term = TW'(sq_res_r[SQN][SQN-1:0]);

  qte_cordic #(.STAGES(CORDIC_STAGES)) u_roll (
    .clk     (clk),
    .en      (adv),
    .y_in    (sq_sr_r[SQN]),
    .x_in    (sq_cr_r[SQN]),
    .ang_out (roll_ang)
  );

  qte_cordic #(.STAGES(CORDIC_STAGES)) u_pitch (
    .clk     (clk),
    .en      (adv),
    .y_in    (sq_sp_r[SQN]),
    .x_in    (cp_term),
    .ang_out (pitch_ang)
  );

  qte_cordic #(.STAGES(CORDIC_STAGES)) u_yaw (
    .clk     (clk),
    .en      (adv),
    .y_in    (sq_sy_r[SQN]),
    .x_in    (sq_cy_r[SQN]),
    .ang_out (yaw_ang)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      dl_clamp_r[0] <= sq_clamp_r[SQN];
      dl_pos_r[0]   <= sq_sp_r[SQN] > 0;
      for (int k = 0; k < CL - 1; k++) begin
        dl_clamp_r[k+1] <= dl_clamp_r[k];
        dl_pos_r[k+1]   <= dl_pos_r[k];
      end
    end
  end

  assign roll_sat  = sat_ang(roll_ang, FULL_SCALE);
  assign yaw_sat   = sat_ang(yaw_ang, FULL_SCALE);
  assign pitch_sat = dl_clamp_r[CL-1] ? (dl_pos_r[CL-1] ? HALF_SCALE : -HALF_SCALE)
                                      : sat_ang(pitch_ang, HALF_SCALE);

  always_ff @(posedge clk) begin
    if (adv) begin
      roll_r  <= roll_sat[15:0];
      yaw_r   <= yaw_sat[15:0];
      pitch_r <= pitch_sat[14:0];
      clamp_r <= dl_clamp_r[CL-1];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_roll_angle    = roll_r;
  assign out_pitch_angle   = pitch_r;
  assign out_yaw_angle     = yaw_r;
  assign out_pitch_clamped = clamp_r;

endmodule
`default_nettype wire

// ===== design/qte_cordic.sv =====
// Pipelined vectoring CORDIC: atan2(y, x) rounded to 1/128 degree.
// One stage per iteration, advanced by a shared enable. Uses qte_pkg.
`default_nettype none
module qte_cordic #(
  parameter int STAGES = qte_pkg::CORDIC_STAGES_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             en,
  input  wire logic signed [qte_pkg::TW-1:0]    y_in,
  input  wire logic signed [qte_pkg::TW-1:0]    x_in,
  output logic signed [qte_pkg::AW-1:0]         ang_out
);
  import qte_pkg::*;

  logic signed [XW-1:0] x_r [0:STAGES];
  logic signed [XW-1:0] y_r [0:STAGES];
  logic signed [ZW-1:0] z_r [0:STAGES];
  logic                 zero_r [0:STAGES];

  logic signed [XW-1:0] x_ext;
  logic signed [XW-1:0] y_ext;
  logic signed [ZW-1:0] rnd;
  logic signed [AW-1:0] ang_r;

  assign x_ext = XW'(x_in);
  assign y_ext = XW'(y_in);

  // quadrant fold for negative x
  always_ff @(posedge clk) begin
    if (en) begin
      zero_r[0] <= (x_in == '0) && (y_in == '0);
      if (x_in < 0) begin
        x_r[0] <= -x_ext;
        y_r[0] <= -y_ext;
        z_r[0] <= (y_in >= 0) ? DEG180_FINE : -DEG180_FINE;
      end else begin
        x_r[0] <= x_ext;
        y_r[0] <= y_ext;
        z_r[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    localparam logic signed [ZW-1:0] ANG = ZW'(atan_deg(i));
    always_ff @(posedge clk) begin
      if (en) begin
        zero_r[i+1] <= zero_r[i];
        if (y_r[i] >= 0) begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + ANG;
        end else begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - ANG;
        end
      end
    end
  end

  assign rnd = z_r[STAGES] + ZW'(256);

  always_ff @(posedge clk) begin
    if (en) begin
      ang_r <= zero_r[STAGES] ? '0 : rnd[ZW-1:9];
    end
  end

  assign ang_out = ang_r;

endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Testbench for quaternion_to_euler_degrees: drives quaternion requests, predicts
// roll/pitch/yaw with an in-bench CORDIC model and checks every result in order.
// Depends on qte_pkg and the quaternion_to_euler_degrees RTL.
`timescale 1ns / 1ps
module tb_top;
  import qte_pkg::*;

  localparam int STAGES = CORDIC_STAGES_DEF;
  localparam longint ONE_Q30 = longint'(1) << 30;
  localparam longint FINE_180 = longint'(180) * 65536;
  localparam longint MAX_CYCLES = 400000;
  localparam longint ATAN_FINE[24] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0};

  typedef struct packed {
    logic signed [15:0] roll;
    logic signed [14:0] pitch;
    logic signed [15:0] yaw;
    logic               clamped;
  } euler_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [15:0] in_quat_w = '0, in_quat_x = '0, in_quat_y = '0, in_quat_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [15:0] out_roll_angle;
  logic signed [14:0] out_pitch_angle;
  logic signed [15:0] out_yaw_angle;
  logic out_pitch_clamped;

  euler_t angles_pending[$];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;
  int mismatches = 0;
  longint cycles = 0;

  quaternion_to_euler_degrees uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_quat_w(in_quat_w), .in_quat_x(in_quat_x),
    .in_quat_y(in_quat_y), .in_quat_z(in_quat_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_roll_angle(out_roll_angle), .out_pitch_angle(out_pitch_angle),
    .out_yaw_angle(out_yaw_angle), .out_pitch_clamped(out_pitch_clamped)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic longint clip(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = longint'(1) << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // vectoring CORDIC, result in 1/128 degree before saturation
  function automatic longint atan2_deg128(longint y, longint x);
    longint ang;
    longint xs, ys;
    ang = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      ang = (y >= 0) ? FINE_180 : -FINE_180;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < STAGES && i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        ang = ang + ATAN_FINE[i];
      end else begin
        x = x - ys;
        y = y + xs;
        ang = ang - ATAN_FINE[i];
      end
    end
    return (ang + 256) >>> 9;
  endfunction

  function automatic euler_t predict_euler(logic signed [15:0] qw, logic signed [15:0] qx,
                                           logic signed [15:0] qy, logic signed [15:0] qz);
    longint w, x, y, z, sr, cr, sp, sy, cy, cp;
    euler_t e;
    w = qw;
    x = qx;
    y = qy;
    z = -longint'(qz);
    sr = 2 * (w * x + y * z);
    cr = ONE_Q30 - 2 * (x * x + y * y);
    sp = 2 * (w * y - z * x);
    sy = 2 * (w * z + x * y);
    cy = ONE_Q30 - 2 * (y * y + z * z);
    e.roll = 16'(clip(atan2_deg128(sr, cr), 23040));
    e.yaw = 16'(clip(atan2_deg128(sy, cy), 23040));
    if (sp >= ONE_Q30 || sp <= -ONE_Q30) begin
      e.pitch = (sp > 0) ? 15'sd11520 : -15'sd11520;
      e.clamped = 1'b1;
    end else begin
      cp = longint'(int_sqrt((longint'(1) << 60) - longint'(sp * sp)));
      e.pitch = 15'(clip(atan2_deg128(sp, cp), 11520));
      e.clamped = 1'b0;
    end
    return e;
  endfunction

  task automatic send_quat(logic signed [15:0] w, logic signed [15:0] x,
                           logic signed [15:0] y, logic signed [15:0] z);
    in_valid <= 1'b1;
    in_quat_w <= w;
    in_quat_x <= x;
    in_quat_y <= y;
    in_quat_z <= z;
    do @(posedge clk); while (!in_ready);
    angles_pending.push_back(predict_euler(w, x, y, z));
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic send_unit_quat();
    real a, b, c, d, n;
    do begin
      a = real'($urandom_range(0, 65535)) - 32768.0;
      b = real'($urandom_range(0, 65535)) - 32768.0;
      c = real'($urandom_range(0, 65535)) - 32768.0;
      d = real'($urandom_range(0, 65535)) - 32768.0;
      n = $sqrt(a * a + b * b + c * c + d * d);
    end while (n < 1.0);
    send_quat(16'($rtoi(a / n * 32767.0)), 16'($rtoi(b / n * 32767.0)),
              16'($rtoi(c / n * 32767.0)), 16'($rtoi(d / n * 32767.0)));
  endtask

  task automatic send_random_quat();
    int kind;
    int s;
    kind = $urandom_range(99);
    if (kind < 60) begin
      send_unit_quat();
    end else if (kind < 75) begin
      // near gimbal lock: w ~ +/-y, x ~ -/+z
      s = $urandom_range(23160, 23180);
      send_quat(16'(s), 16'($urandom_range(0, 40) - 20), ($urandom_range(1)) ? 16'(s) : -16'(s),
                16'($urandom_range(0, 40) - 20));
    end else if (kind < 85) begin
      send_quat(16'($urandom_range(0, 511) - 256), 16'($urandom_range(0, 511) - 256),
                16'($urandom_range(0, 511) - 256), 16'($urandom_range(0, 511) - 256));
    end else begin
      send_quat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    end
  endtask

  task automatic test_directed();
    send_quat(16'sd32767, 0, 0, 0);
    send_quat(0, 0, 0, 0);
    send_quat(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768);
    send_quat(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767);
    send_quat(0, 16'sd32767, 0, 0);
    send_quat(0, -16'sd32768, 0, 0);
    send_quat(0, 0, 0, 16'sd32767);
    send_quat(0, 0, 0, -16'sd32768);
    send_quat(0, 16'sd16384, 16'sd16384, 0);
    send_quat(0, 16'sd16384, -16'sd16384, 0);
    send_quat(16'sd23171, 0, 16'sd23171, 0);
    send_quat(16'sd23171, 0, -16'sd23171, 0);
    send_quat(16'sd23170, 0, 16'sd23170, 0);
    send_quat(16'sd23170, 0, -16'sd23170, 0);
    send_quat(0, 16'sd23171, 0, -16'sd23171);
    send_quat(16'sd100, 16'sd32767, 0, 0);
    send_quat(-16'sd100, 16'sd32767, 0, 0);
    send_quat(16'sd100, 0, 0, 16'sd32767);
    send_quat(-16'sd100, 0, 0, 16'sd32767);
    send_quat(16'sd32767, 16'sd32767, 0, 0);
    send_quat(16'sd1, -16'sd1, 16'sd1, -16'sd1);
    send_quat(16'sd23170, 16'sd23170, 16'sd23170, -16'sd23170);
  endtask

  task automatic test_random(int n, int snd, int rcv);
    send_idle_pct = snd;
    recv_stall_pct = rcv;
    repeat (n) send_random_quat();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_left = 300;
    repeat (120) send_random_quat();
  endtask

  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    euler_t exp_e;
    if (rst_n && out_valid && out_ready) begin
      if (angles_pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result roll=%0d", out_roll_angle);
      end else begin
        exp_e = angles_pending.pop_front();
        if (out_roll_angle !== exp_e.roll || out_pitch_angle !== exp_e.pitch ||
            out_yaw_angle !== exp_e.yaw || out_pitch_clamped !== exp_e.clamped) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp r/p/y/c %0d %0d %0d %0d got %0d %0d %0d %0d",
                     exp_e.roll, exp_e.pitch, exp_e.yaw, exp_e.clamped, out_roll_angle,
                     out_pitch_angle, out_yaw_angle, out_pitch_clamped);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(180, 8, 52);
    test_random(180, 52, 8);
    test_random(70, 0, 0);
    test_backpressure();
    in_valid <= 1'b0;
    recv_stall_pct = 0;
    while (angles_pending.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
